[src/mcu_pkg.sv]
// Shared types and codes for the microprogrammed control unit.
// Holds request codes, microword field codes and the register file struct.
// No dependencies.
`default_nettype none

package mcu_pkg;

  typedef enum logic [1:0] {
    FUNC_LOAD_CTRL = 2'd0,
    FUNC_LOAD_MEM  = 2'd1,
    FUNC_STEP      = 2'd2,
    FUNC_READ_MEM  = 2'd3
  } func_e;

  // F1 microoperations.
  localparam logic [2:0] F1_NOP   = 3'd0;
  localparam logic [2:0] F1_ADD   = 3'd1;
  localparam logic [2:0] F1_CLRAC = 3'd2;
  localparam logic [2:0] F1_INCAC = 3'd3;
  localparam logic [2:0] F1_DRTAC = 3'd4;
  localparam logic [2:0] F1_DRTAR = 3'd5;
  localparam logic [2:0] F1_PCTAR = 3'd6;
  localparam logic [2:0] F1_WRITE = 3'd7;

  // F2 microoperations.
  localparam logic [2:0] F2_NOP   = 3'd0;
  localparam logic [2:0] F2_SUB   = 3'd1;
  localparam logic [2:0] F2_OR    = 3'd2;
  localparam logic [2:0] F2_AND   = 3'd3;
  localparam logic [2:0] F2_READ  = 3'd4;
  localparam logic [2:0] F2_ACTDR = 3'd5;
  localparam logic [2:0] F2_INCDR = 3'd6;
  localparam logic [2:0] F2_PCTDR = 3'd7;

  // F3 microoperations.
  localparam logic [2:0] F3_NOP   = 3'd0;
  localparam logic [2:0] F3_XOR   = 3'd1;
  localparam logic [2:0] F3_COM   = 3'd2;
  localparam logic [2:0] F3_SHL   = 3'd3;
  localparam logic [2:0] F3_SHR   = 3'd4;
  localparam logic [2:0] F3_INCPC = 3'd5;
  localparam logic [2:0] F3_ARTPC = 3'd6;
  localparam logic [2:0] F3_RSVD  = 3'd7;

  // Condition select.
  localparam logic [1:0] CD_ALWAYS = 2'd0;
  localparam logic [1:0] CD_DRSIGN = 2'd1;
  localparam logic [1:0] CD_ACSIGN = 2'd2;
  localparam logic [1:0] CD_ACZERO = 2'd3;

  // Branch type.
  localparam logic [1:0] BR_JMP  = 2'd0;
  localparam logic [1:0] BR_CALL = 2'd1;
  localparam logic [1:0] BR_RET  = 2'd2;
  localparam logic [1:0] BR_MAP  = 2'd3;

  localparam logic [6:0] CAR_RESET = 7'b1000000;

  typedef struct packed {
    logic [2:0] f1;
    logic [2:0] f2;
    logic [2:0] f3;
    logic [1:0] cd;
    logic [1:0] br;
    logic [6:0] ad;
  } uword_t;

  typedef struct packed {
    logic [15:0] ac;
    logic [15:0] dr;
    logic [10:0] ar;
    logic [10:0] pc;
    logic [6:0]  car;
    logic [6:0]  sbr;
    logic        e;
  } arch_t;

endpackage

`default_nettype wire

[src/mcu_ram.sv]
// Single-port-write, single-port-read memory with a registered read.
// Used for both the control store and the main memory. No dependencies.
`default_nettype none

module mcu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[src/mcu_datapath.sv]
// Architectural registers and microoperation logic of the basic computer.
// Executes one microword per step. Depends on mcu_pkg.
`default_nettype none

module mcu_datapath import mcu_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire uword_t      uword_i,
  input  wire logic [15:0] mem_rdata_i,
  output arch_t            cur_o,
  output arch_t            nxt_o
);

  arch_t regs_q, calc;
  logic [16:0] sum;
  logic cond;

  always_comb begin
    calc = regs_q;
    sum  = {1'b0, regs_q.ac} + {1'b0, regs_q.dr};

    // Later fields override earlier ones; all read start-of-step values.
    unique case (uword_i.f1)
      F1_ADD:   begin calc.ac = sum[15:0]; calc.e = sum[16]; end
      F1_CLRAC: calc.ac = '0;
      F1_INCAC: calc.ac = regs_q.ac + 16'd1;
      F1_DRTAC: calc.ac = regs_q.dr;
      F1_DRTAR: calc.ar = regs_q.dr[10:0];
      F1_PCTAR: calc.ar = regs_q.pc;
      F1_NOP, F1_WRITE: ;
      default: ;
    endcase

    unique case (uword_i.f2)
      F2_SUB:   calc.ac = regs_q.ac - regs_q.dr;
      F2_OR:    calc.ac = regs_q.ac | regs_q.dr;
      F2_AND:   calc.ac = regs_q.ac & regs_q.dr;
      F2_READ:  calc.dr = mem_rdata_i;
      F2_ACTDR: calc.dr = regs_q.ac;
      F2_INCDR: calc.dr = regs_q.dr + 16'd1;
      F2_PCTDR: calc.dr = {regs_q.dr[15:11], regs_q.pc};
      F2_NOP:   ;
      default: ;
    endcase

    unique case (uword_i.f3)
      F3_XOR:   calc.ac = regs_q.ac ^ regs_q.dr;
      F3_COM:   calc.ac = ~regs_q.ac;
      F3_SHL:   begin calc.ac = {regs_q.ac[14:0], regs_q.e}; calc.e = regs_q.ac[15]; end
      F3_SHR:   begin calc.ac = {regs_q.e, regs_q.ac[15:1]}; calc.e = regs_q.ac[0]; end
      F3_INCPC: calc.pc = regs_q.pc + 11'd1;
      F3_ARTPC: calc.pc = regs_q.ar;
      F3_NOP, F3_RSVD: ;
      default: ;
    endcase

    unique case (uword_i.cd)
      CD_ALWAYS: cond = 1'b1;
      CD_DRSIGN: cond = regs_q.dr[15];
      CD_ACSIGN: cond = regs_q.ac[15];
      CD_ACZERO: cond = (regs_q.ac == 16'd0);
      default:   cond = 1'b1;
    endcase

    // Untaken return or map leaves the control address where it is.
    unique case (uword_i.br)
      BR_JMP:  calc.car = cond ? uword_i.ad : regs_q.car + 7'd1;
      BR_CALL: begin
        if (cond) begin
          calc.sbr = regs_q.car + 7'd1;
          calc.car = uword_i.ad;
        end else begin
          calc.car = regs_q.car + 7'd1;
        end
      end
      BR_RET:  if (cond) calc.car = regs_q.sbr;
      BR_MAP:  if (cond) calc.car = {1'b0, regs_q.dr[14:11], 2'b00};
      default: ;
    endcase
  end

  assign nxt_o = step_i ? calc : regs_q;
  assign cur_o = regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= '{ac: '0, dr: '0, ar: '0, pc: '0, car: CAR_RESET, sbr: '0, e: 1'b0};
    end else if (step_i) begin
      regs_q <= calc;
    end
  end

endmodule

`default_nettype wire

[src/microprogrammed_control_unit.sv]
// Top level of the microprogrammed control unit: sequencer, stores, output register.
// Depends on mcu_pkg, mcu_ram and mcu_datapath.
//
// Requests arrive on the in channel (func, address, data) and each one
// produces exactly one result on the out channel: a snapshot of AC, DR, AR,
// PC, CAR, SBR and E after the request, plus the memory word for a read.
// A request is one of: load a control word, load a memory word, execute one
// microinstruction, or read a memory word.
// Every request passes through two states: in the accept cycle the control store is
// read at CAR and main memory at AR (or at the request address for a read),
// and load requests write their store; in the execute cycle the microword
// executes, a WRITE microoperation writes memory, and the result lands in the
// output register. The next request is taken only after the execute cycle, a split
// set by the registered reads of the two memories.
// The output register holds a finished result while the receiver stalls;
// a new request may be accepted meanwhile, and its execute cycle waits
// until the held result is taken.
// Reset clears the registers and sets CAR to 64; the control store and
// main memory keep their contents and must be written before being read.
`default_nettype none

module microprogrammed_control_unit import mcu_pkg::*; #(
  parameter int CONTROL_WORDS = 128,
  parameter int MEMORY_WORDS  = 2048
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [10:0] address_i,
  input  wire logic [19:0] data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      acc_o,
  output logic [15:0]      data_reg_o,
  output logic [10:0]      addr_reg_o,
  output logic [10:0]      prog_count_o,
  output logic [6:0]       micro_addr_o,
  output logic [6:0]       return_addr_o,
  output logic             carry_flag_o,
  output logic [15:0]      read_word_o
);

  localparam int CW = $clog2(CONTROL_WORDS);
  localparam int MW = $clog2(MEMORY_WORDS);
  localparam logic [11:0] CTRL_LIMIT = 12'(CONTROL_WORDS);
  localparam logic [11:0] MEM_LIMIT  = 12'(MEMORY_WORDS);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic state_q, state_d;
  func_e func_q, func_in;
  logic ctrl_ok_q, mem_ok_q, out_valid_q;
  logic accept, done, step_commit;

  arch_t cur, nxt;
  uword_t uword;
  logic [19:0] ctrl_rdata;
  logic [15:0] mem_rdata, mem_word;

  logic        ctrl_we;
  logic        mem_we, mem_rd_ok;
  logic [10:0] mem_raddr, mem_waddr;
  logic [15:0] mem_wdata;

  assign func_in     = func_e'(func_i);
  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign done        = (state_q == ST_BUSY) && (!out_valid_q || out_ready_i);
  assign step_commit = done && (func_q == FUNC_STEP);

  // Control store: loads and fetches both happen in the accept cycle.
  assign ctrl_we = accept && (func_in == FUNC_LOAD_CTRL) && ({1'b0, address_i} < CTRL_LIMIT);

  mcu_ram #(
    .WIDTH (20),
    .DEPTH (CONTROL_WORDS)
  ) u_ctrl_store (
    .clk_i   (clk_i),
    .we_i    (ctrl_we),
    .waddr_i (address_i[CW-1:0]),
    .wdata_i (data_i),
    .re_i    (accept),
    .raddr_i (cur.car[CW-1:0]),
    .rdata_o (ctrl_rdata)
  );

  // Main memory: the step's read is done before its write, so DR sees the old word.
  assign mem_raddr = (func_in == FUNC_READ_MEM) ? address_i : cur.ar;
  assign mem_rd_ok = ({1'b0, mem_raddr} < MEM_LIMIT);
  assign mem_waddr = accept ? address_i : cur.ar;
  assign mem_wdata = accept ? data_i[15:0] : cur.dr;
  assign mem_we    = (accept && (func_in == FUNC_LOAD_MEM) && ({1'b0, address_i} < MEM_LIMIT))
                  || (step_commit && (uword.f1 == F1_WRITE) && ({1'b0, cur.ar} < MEM_LIMIT));

  mcu_ram #(
    .WIDTH (16),
    .DEPTH (MEMORY_WORDS)
  ) u_main_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr[MW-1:0]),
    .wdata_i (mem_wdata),
    .re_i    (accept),
    .raddr_i (mem_raddr[MW-1:0]),
    .rdata_o (mem_rdata)
  );

  assign uword    = ctrl_ok_q ? uword_t'(ctrl_rdata) : '0;
  assign mem_word = mem_ok_q ? mem_rdata : '0;

  mcu_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step_commit),
    .uword_i     (uword),
    .mem_rdata_i (mem_word),
    .cur_o       (cur),
    .nxt_o       (nxt)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_BUSY;
      ST_BUSY: if (done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q    <= func_in;
      ctrl_ok_q <= ({5'd0, cur.car} < CTRL_LIMIT);
      mem_ok_q  <= mem_rd_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      acc_o         <= nxt.ac;
      data_reg_o    <= nxt.dr;
      addr_reg_o    <= nxt.ar;
      prog_count_o  <= nxt.pc;
      micro_addr_o  <= nxt.car;
      return_addr_o <= nxt.sbr;
      carry_flag_o  <= nxt.e;
      read_word_o   <= (func_q == FUNC_READ_MEM) ? mem_word : '0;
    end
  end

  assign out_valid_o = out_valid_q;

  // A request always passes through the execute state before the next is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted on consecutive cycles");

  // A new result appears only out of the execute cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_BUSY)
    else $error("result raised without an execute cycle");

  // The control address moves only when a microinstruction commits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_commit |=> $stable(cur.car))
    else $error("control address changed outside a step");

endmodule

`default_nettype wire
